@@ rtl/rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants for the rectangular-to-polar bin converter.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_BITS    = 16;
  localparam int ANGLE_WIDTH   = 32;
  localparam int TABLE_LEN     = 24;

  // Datapath width: sample, guard bits, growth by the CORDIC gain and sign.
  localparam int XW     = SAMPLE_WIDTH + GUARD_BITS + 4;
  localparam int UXW    = XW - 1;
  localparam int LO_W   = UXW / 2;
  localparam int HI_W   = UXW - LO_W;
  localparam int GAIN_W = 32;
  localparam int PROD_W = HI_W + GAIN_W + LO_W;

  localparam logic [GAIN_W-1:0]      GAIN_Q32     = 32'h9B74_EDA8;
  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [ANGLE_WIDTH-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  typedef struct packed {
    logic                    special;
    logic [SAMPLE_WIDTH-1:0] smag;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic [ANGLE_WIDTH-1:0]  acc;
    logic                    last;
  } item_t;

endpackage

@@ rtl/rtp_entry.sv @@
// ----------------------------------------------------------------------------
// rtp_entry
// Input stage: detects axis-aligned inputs and pre-rotates into the right half.
// ----------------------------------------------------------------------------
module rtp_entry (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rtp_pkg::SAMPLE_WIDTH-1:0] re,
  input  logic signed [rtp_pkg::SAMPLE_WIDTH-1:0] im,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rtp_pkg::item_t                        out_item
);
  import rtp_pkg::*;

  logic           valid;
  item_t          item;
  item_t          item_next;
  logic [XW-1:0]  re_x;
  logic [XW-1:0]  im_x;
  logic [SAMPLE_WIDTH:0] re_abs;
  logic [SAMPLE_WIDTH:0] im_abs;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_comb begin
    re_x   = {{(XW-SAMPLE_WIDTH){re[SAMPLE_WIDTH-1]}}, re};
    im_x   = {{(XW-SAMPLE_WIDTH){im[SAMPLE_WIDTH-1]}}, im};
    re_abs = re[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-re_x) : (SAMPLE_WIDTH+1)'(re_x);
    im_abs = im[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+1)'(-im_x) : (SAMPLE_WIDTH+1)'(im_x);
    item_next.last    = last;
    item_next.special = 1'b1;
    item_next.smag    = '0;
    item_next.acc     = '0;
    x0 = re_x;
    y0 = im_x;
    if (re[SAMPLE_WIDTH-1]) begin
      if (!im[SAMPLE_WIDTH-1]) begin
        x0 = im_x;
        y0 = -re_x;
        item_next.acc = QUARTER_TURN;
      end else begin
        x0 = -im_x;
        y0 = re_x;
        item_next.acc = -QUARTER_TURN;
      end
    end
    item_next.x = x0 <<< GUARD_BITS;
    item_next.y = y0 <<< GUARD_BITS;
    priority if (re == '0 && im == '0) begin
      item_next.acc = '0;
    end else if (im == '0) begin
      item_next.smag = re_abs[SAMPLE_WIDTH-1:0];
      item_next.acc  = re[SAMPLE_WIDTH-1] ? HALF_TURN : '0;
    end else if (re == '0) begin
      item_next.smag = im_abs[SAMPLE_WIDTH-1:0];
      item_next.acc  = im[SAMPLE_WIDTH-1] ? -QUARTER_TURN : QUARTER_TURN;
    end else begin
      item_next.special = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

@@ rtl/rtp_cordic.sv @@
// ----------------------------------------------------------------------------
// rtp_cordic
// Vectoring CORDIC, one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module rtp_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rtp_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output rtp_pkg::item_t out_item
);
  import rtp_pkg::*;

  localparam int NST = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  logic  stage_v   [NST];
  logic  stage_rdy [NST];
  item_t stage_d   [NST];

  assign in_ready  = stage_rdy[0];
  assign out_valid = stage_v[NST-1];
  assign out_item  = stage_d[NST-1];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic  src_v;
    item_t src;
    item_t nxt;
    logic  down_rdy;

    if (k == 0) begin : g_first
      assign src_v = in_valid;
      assign src   = in_item;
    end else begin : g_mid
      assign src_v = stage_v[k-1];
      assign src   = stage_d[k-1];
    end

    if (k == NST - 1) begin : g_last
      assign down_rdy = out_ready;
    end else begin : g_inner
      assign down_rdy = stage_rdy[k+1];
    end

    assign stage_rdy[k] = !stage_v[k] || down_rdy;

    always_comb begin
      nxt = src;
      if (!src.special) begin
        if (!src.y[XW-1]) begin
          nxt.x   = src.x + (src.y >>> k);
          nxt.y   = src.y - (src.x >>> k);
          nxt.acc = src.acc + ATAN_TABLE[k];
        end else begin
          nxt.x   = src.x - (src.y >>> k);
          nxt.y   = src.y + (src.x >>> k);
          nxt.acc = src.acc - ATAN_TABLE[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_v[k] <= 1'b0;
      end else if (stage_rdy[k]) begin
        stage_v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_rdy[k] && src_v) begin
        stage_d[k] <= nxt;
      end
    end
  end

endmodule

@@ rtl/rtp_scale.sv @@
// ----------------------------------------------------------------------------
// rtp_scale
// Gain correction of the magnitude in two partial products, phase rounding.
// ----------------------------------------------------------------------------
module rtp_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rtp_pkg::item_t                    in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rtp_pkg::SAMPLE_WIDTH-1:0]  magnitude,
  output logic [rtp_pkg::SAMPLE_WIDTH-1:0]  phase,
  output logic                              last_out
);
  import rtp_pkg::*;

  localparam int QW = PROD_W - ANGLE_WIDTH + 1;
  localparam int MW = QW - GUARD_BITS;

  logic                    v1;
  logic                    rdy1;
  logic [LO_W+GAIN_W-1:0]  pp_lo;
  logic [HI_W+GAIN_W-1:0]  pp_hi;
  logic                    special1;
  logic [SAMPLE_WIDTH-1:0] smag1;
  logic [ANGLE_WIDTH-1:0]  acc1;
  logic                    last1;
  logic [UXW-1:0]          ux;

  logic                    v2;
  logic                    rdy2;
  logic [PROD_W-1:0]       prod;
  logic [QW-1:0]           q;
  logic [MW-1:0]           m;
  logic [SAMPLE_WIDTH-1:0] mag_next;
  logic [ANGLE_WIDTH-1:0]  acc_rnd;

  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;

  assign ux = in_item.x[XW-1] ? '0 : in_item.x[UXW-1:0];

  always_comb begin
    prod = {pp_hi, {LO_W{1'b0}}} + PROD_W'(pp_lo);
    q    = QW'(prod[PROD_W-1:ANGLE_WIDTH]) + QW'(1 << (GUARD_BITS - 1));
    m    = q[QW-1:GUARD_BITS];
    if (special1) begin
      mag_next = smag1;
    end else if (m > MW'({SAMPLE_WIDTH{1'b1}})) begin
      mag_next = '1;
    end else begin
      mag_next = m[SAMPLE_WIDTH-1:0];
    end
    acc_rnd = acc1 + ANGLE_WIDTH'(1 << (ANGLE_WIDTH - SAMPLE_WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      pp_lo    <= (LO_W+GAIN_W)'(ux[LO_W-1:0]) * (LO_W+GAIN_W)'(GAIN_Q32);
      pp_hi    <= (HI_W+GAIN_W)'(ux[UXW-1:LO_W]) * (HI_W+GAIN_W)'(GAIN_Q32);
      special1 <= in_item.special;
      smag1    <= in_item.smag;
      acc1     <= in_item.acc;
      last1    <= in_item.last;
    end
    if (rdy2 && v1) begin
      magnitude <= mag_next;
      phase     <= acc_rnd[ANGLE_WIDTH-1:ANGLE_WIDTH-SAMPLE_WIDTH];
      last_out  <= last1;
    end
  end

endmodule

@@ rtl/rect_to_polar_bin.sv @@
// ----------------------------------------------------------------------------
// rect_to_polar_bin
// Converts one complex spectrum bin per cycle to magnitude and phase while m_axis_tready is high.
// ----------------------------------------------------------------------------
// The pipeline has one input stage, one per CORDIC micro-rotation (16),
// and two for the split gain multiply and rounding.
// Throughput is one bin per cycle while m_axis_tready is high; every stage holds its own valid bit.
// Reset clears only the valid bits; the block keeps no state between bins.
// ----------------------------------------------------------------------------
module rect_to_polar_bin (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // real_part[15:0], imag_part[31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // magnitude[15:0], phase[31:16]
  output logic        m_axis_tlast
);
  import rtp_pkg::*;

  logic                    e_valid;
  logic                    e_ready;
  item_t                   e_item;
  logic                    c_valid;
  logic                    c_ready;
  item_t                   c_item;
  logic [SAMPLE_WIDTH-1:0] magnitude;
  logic [SAMPLE_WIDTH-1:0] phase;

  rtp_entry u_entry (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .re        (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .im        (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .last      (s_axis_tlast),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .out_item  (e_item)
  );

  rtp_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .in_item   (e_item),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_item  (c_item)
  );

  rtp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_item   (c_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .magnitude (magnitude),
    .phase     (phase),
    .last_out  (m_axis_tlast)
  );

  assign m_axis_tdata = {phase, magnitude};

endmodule
